>>> sv/tasd_pkg.sv
package tasd_pkg;

    localparam int DP_W     = 36;
    localparam int TABLE_LEN = 24;
    localparam int GAIN_Q16 = 107922;
    localparam int LIMIT_W  = 15;

    typedef logic signed [DP_W-1:0] t_dp;
    typedef logic signed [15:0]     t_s16;

    localparam t_dp HALF_TURN_Q16 = t_dp'(64'sd1179648000);

    function automatic t_dp atan_q16(input int idx);
        t_dp v;
        case (idx)
            0:  v = t_dp'(64'sd294912000);
            1:  v = t_dp'(64'sd174096719);
            2:  v = t_dp'(64'sd91987925);
            3:  v = t_dp'(64'sd46694507);
            4:  v = t_dp'(64'sd23437864);
            5:  v = t_dp'(64'sd11730358);
            6:  v = t_dp'(64'sd5866610);
            7:  v = t_dp'(64'sd2933484);
            8:  v = t_dp'(64'sd1466764);
            9:  v = t_dp'(64'sd733385);
            10: v = t_dp'(64'sd366693);
            11: v = t_dp'(64'sd183346);
            12: v = t_dp'(64'sd91673);
            13: v = t_dp'(64'sd45837);
            14: v = t_dp'(64'sd22918);
            15: v = t_dp'(64'sd11459);
            16: v = t_dp'(64'sd5730);
            17: v = t_dp'(64'sd2865);
            18: v = t_dp'(64'sd1432);
            19: v = t_dp'(64'sd716);
            20: v = t_dp'(64'sd358);
            21: v = t_dp'(64'sd179);
            22: v = t_dp'(64'sd90);
            23: v = t_dp'(64'sd45);
            default: v = '0;
        endcase
        return v;
    endfunction

    // round to nearest centidegree (ties up), then clamp to +-lim
    function automatic t_s16 to_centideg(input t_dp ang, input int lim);
        t_dp c;
        t_dp l;
        c = (ang + t_dp'(32768)) >>> 16;
        l = t_dp'(lim);
        if (c > l) c = l;
        if (c < -l) c = -l;
        return t_s16'(c);
    endfunction

endpackage

>>> sv/tilt_angle_servo_drive.sv
// Tilt angle and servo drive.
// Input channel: i_in_valid / o_in_stall with accel_x/y/z samples; one item
// per cycle is taken whenever o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with roll, pitch (centidegrees),
// servo pulse width (us) and the tilted flag; one result per input item.
// Path: the roll CORDIC cell chain, a handoff register that forms the pitch
// vector, the pitch CORDIC cell chain, and the output register.
// Throughput: one item per cycle while the receiver does not stall; set by
// the cell chains, one CORDIC iteration per cell.
// The whole pipeline advances together. While a result sits in the output
// register and the receiver stalls, the pipeline holds and o_in_stall is high.
// i_cfg_we writes the tilt limit at any clock edge; change it only while the
// block is empty.
// Reset (synchronous, active low) drops every item in flight and sets the
// tilt limit to 1500.
module tilt_angle_servo_drive #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_accel_z,
    input  logic                 i_cfg_we,
    input  logic [14:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [15:0]   o_roll_centideg,
    output logic signed [14:0]   o_pitch_centideg,
    output logic [11:0]          o_servo_pulse_us,
    output logic                 o_tilted
);
    import tasd_pkg::*;

    logic en;
    logic [LIMIT_W-1:0] r_limit;

    // roll chain
    logic rv [0:CORDIC_STAGES];
    t_dp  rx [0:CORDIC_STAGES];
    t_dp  ry [0:CORDIC_STAGES];
    t_dp  ra [0:CORDIC_STAGES];
    logic [15:0] rax [0:CORDIC_STAGES];

    // pitch chain
    logic pv [0:CORDIC_STAGES];
    t_dp  px [0:CORDIC_STAGES];
    t_dp  py [0:CORDIC_STAGES];
    t_dp  pa [0:CORDIC_STAGES];
    logic [15:0] proll [0:CORDIC_STAGES];

    t_dp in_x, in_y, in_ang, in_z0, in_y0;
    t_dp n_m_y;
    t_s16 n_m_roll;
    logic r_m_valid;
    t_dp r_m_x, r_m_y;
    t_s16 r_m_roll;

    t_s16 fin_roll, fin_pitch;
    logic signed [16:0] v;
    logic [31:0] q;
    logic [11:0] n_pulse;
    logic [15:0] aroll, apitch;
    logic n_tilt;
    logic r_o_valid;
    t_s16 r_o_roll;
    logic signed [14:0] r_o_pitch;
    logic [11:0] r_o_pulse;
    logic r_o_tilt;

    assign en = !(r_o_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(1500);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // roll pass entry: left half-plane is turned by 180 degrees first
    assign in_z0 = t_dp'(i_accel_z) <<< 14;
    assign in_y0 = t_dp'(i_accel_y) <<< 14;
    always_comb begin
        in_x = in_z0;
        in_y = in_y0;
        in_ang = '0;
        if (i_accel_z < 0) begin
            in_x = -in_z0;
            in_y = -in_y0;
            in_ang = (i_accel_y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
        end
    end

    assign rv[0] = i_in_valid;
    assign rx[0] = in_x;
    assign ry[0] = in_y;
    assign ra[0] = in_ang;
    assign rax[0] = i_accel_x;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_roll
        tasd_cell #(.STAGE(g), .AUX_W(16)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(rv[g]), .i_x(rx[g]), .i_y(ry[g]), .i_ang(ra[g]), .i_aux(rax[g]),
            .o_valid(rv[g+1]), .o_x(rx[g+1]), .o_y(ry[g+1]), .o_ang(ra[g+1]),
            .o_aux(rax[g+1])
        );
    end

    // handoff: pitch y = floor(-x * 2^14 * gain / 2^16)
    assign n_m_y = (-(t_dp'($signed(rax[CORDIC_STAGES]))) * t_dp'(GAIN_Q16)) >>> 2;
    assign n_m_roll = to_centideg(ra[CORDIC_STAGES], 18000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= rv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_x <= rx[CORDIC_STAGES];
            r_m_y <= n_m_y;
            r_m_roll <= n_m_roll;
        end
    end

    assign pv[0] = r_m_valid;
    assign px[0] = r_m_x;
    assign py[0] = r_m_y;
    assign pa[0] = '0;
    assign proll[0] = r_m_roll;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pitch
        tasd_cell #(.STAGE(g), .AUX_W(16)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(pv[g]), .i_x(px[g]), .i_y(py[g]), .i_ang(pa[g]), .i_aux(proll[g]),
            .o_valid(pv[g+1]), .o_x(px[g+1]), .o_y(py[g+1]), .o_ang(pa[g+1]),
            .o_aux(proll[g+1])
        );
    end

    // output stage: pitch rounding, servo width, tilt compare
    assign fin_roll = $signed(proll[CORDIC_STAGES]);
    assign fin_pitch = to_centideg(pa[CORDIC_STAGES], 9000);
    assign v = 17'(fin_roll) + 17'sd9000;
    // v / 9 as v * ceil(2^18/9) >> 18, exact for v < 32768
    assign q = (32'(v[15:0]) * 32'd29128) >> 18;

    always_comb begin
        if (v <= 0) begin
            n_pulse = 12'd500;
        end else if (q + 32'd500 > 32'd2500) begin
            n_pulse = 12'd2500;
        end else begin
            n_pulse = 12'(q + 32'd500);
        end
    end

    assign aroll = (fin_roll < 0) ? 16'(-fin_roll) : 16'(fin_roll);
    assign apitch = (fin_pitch < 0) ? 16'(-fin_pitch) : 16'(fin_pitch);
    assign n_tilt = (aroll > {1'b0, r_limit}) || (apitch > {1'b0, r_limit});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= pv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_roll <= fin_roll;
            r_o_pitch <= fin_pitch[14:0];
            r_o_pulse <= n_pulse;
            r_o_tilt <= n_tilt;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_roll_centideg = r_o_roll;
    assign o_pitch_centideg = r_o_pitch;
    assign o_servo_pulse_us = r_o_pulse;
    assign o_tilted = r_o_tilt;

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_servo_pulse_us >= 12'd500 && o_servo_pulse_us <= 12'd2500))
        else $error("servo width out of range");
    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_roll_centideg >= -16'sd18000 && o_roll_centideg <= 16'sd18000))
        else $error("roll out of range");
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch_centideg >= -15'sd9000 && o_pitch_centideg <= 15'sd9000))
        else $error("pitch out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> (o_out_valid && $stable(o_roll_centideg) && $stable(o_tilted)))
        else $error("pipeline moved while held");

endmodule

>>> sv/tasd_cell.sv
module tasd_cell #(
    parameter int STAGE = 0,
    parameter int AUX_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  tasd_pkg::t_dp      i_x,
    input  tasd_pkg::t_dp      i_y,
    input  tasd_pkg::t_dp      i_ang,
    input  logic [AUX_W-1:0]   i_aux,
    output logic               o_valid,
    output tasd_pkg::t_dp      o_x,
    output tasd_pkg::t_dp      o_y,
    output tasd_pkg::t_dp      o_ang,
    output logic [AUX_W-1:0]   o_aux
);
    import tasd_pkg::*;

    t_dp dx, dy, n_x, n_y, n_ang;
    logic r_valid;
    t_dp r_x, r_y, r_ang;
    logic [AUX_W-1:0] r_aux;

    assign dx = i_y >>> STAGE;
    assign dy = i_x >>> STAGE;

    // y > 0 rotates back, y < 0 forward, y == 0 holds
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_ang = i_ang;
        if (i_y > 0) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_ang = i_ang + atan_q16(STAGE);
        end else if (i_y < 0) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_ang = i_ang - atan_q16(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_ang <= n_ang;
            r_aux <= i_aux;
        end
    end

    assign o_valid = r_valid;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_ang = r_ang;
    assign o_aux = r_aux;

endmodule
